// File: design/rfhp_pkg.sv
// ----------------------------------------------------------------------------
// Radar frame header parser package
// Shared constants, word kinds and the byte struct used between stages.
// ----------------------------------------------------------------------------
package rfhp_pkg;

    localparam int PHASE_W = 5;

    // Phase codes: 0..7 check magic bytes, 8..17 assemble header fields.
    localparam logic [PHASE_W-1:0] PHASE_HUNT     = 5'd0;
    localparam logic [PHASE_W-1:0] PHASE_MAGIC_LAST = 5'd7;
    localparam logic [PHASE_W-1:0] FIELD_FIRST    = 5'd8;
    localparam logic [PHASE_W-1:0] FIELD_LENGTH   = 5'd9;
    localparam logic [PHASE_W-1:0] FIELD_PLATFORM = 5'd10;
    localparam logic [PHASE_W-1:0] FIELD_LAST     = 5'd17;
    localparam logic [PHASE_W-1:0] PHASE_PAYLOAD  = 5'd18;

    localparam logic [32:0] HEADER_BYTES = 33'd48;
    localparam logic [1:0]  BYTE_LAST    = 2'd3;

    typedef enum logic [3:0] {
        KIND_VERSION  = 4'd0,
        KIND_LENGTH   = 4'd1,
        KIND_FRAME    = 4'd2,
        KIND_CYCLES   = 4'd3,
        KIND_OBJECTS  = 4'd4,
        KIND_TLV_CNT  = 4'd5,
        KIND_SUBFRAME = 4'd6,
        KIND_TLV_TYPE = 4'd7,
        KIND_TLV_LEN  = 4'd8,
        KIND_PAYLOAD  = 4'd9,
        KIND_NONE     = 4'd15
    } rfhp_kind_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } rfhp_byte_t;

    function automatic logic [7:0] magic_byte(input logic [2:0] pos);
        logic [7:0] b;
        case (pos)
            3'd0:    b = 8'h02;
            3'd1:    b = 8'h01;
            3'd2:    b = 8'h04;
            3'd3:    b = 8'h03;
            3'd4:    b = 8'h06;
            3'd5:    b = 8'h05;
            3'd6:    b = 8'h08;
            3'd7:    b = 8'h07;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic rfhp_kind_t field_kind(input logic [PHASE_W-1:0] phase);
        rfhp_kind_t k;
        case (phase)
            5'd8:    k = KIND_VERSION;
            5'd9:    k = KIND_LENGTH;
            5'd11:   k = KIND_FRAME;
            5'd12:   k = KIND_CYCLES;
            5'd13:   k = KIND_OBJECTS;
            5'd14:   k = KIND_TLV_CNT;
            5'd15:   k = KIND_SUBFRAME;
            5'd16:   k = KIND_TLV_TYPE;
            5'd17:   k = KIND_TLV_LEN;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

// File: design/rfhp_in_reg.sv
// ----------------------------------------------------------------------------
// Radar frame header parser input register
// Holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module rfhp_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        rx_byte,
    input  logic              take,
    output rfhp_pkg::rfhp_byte_t held
);
    import rfhp_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= rx_byte;
        end
    end

    assign held.valid = valid_reg;
    assign held.data  = data_reg;

endmodule

// File: design/rfhp_parse.sv
// ----------------------------------------------------------------------------
// Radar frame header parser core
// Magic word hunt, header field assembly, payload count and result register.
// ----------------------------------------------------------------------------
module rfhp_parse (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rfhp_pkg::rfhp_byte_t held,
    output logic                 take,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [3:0]           item_kind,
    output logic [31:0]          item_value,
    output logic [15:0]          payload_index,
    output logic                 frame_end
);
    import rfhp_pkg::*;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [1:0]         byte_in_field_reg, byte_in_field_next;
    logic [31:0]        field_acc_reg, field_acc_next;
    logic [31:0]        packet_length_reg, packet_length_next;
    logic [31:0]        payload_count_reg, payload_count_next;
    logic               out_valid_reg, out_valid_next;
    logic [3:0]         kind_reg;
    logic [31:0]        value_reg;
    logic [15:0]        index_reg;
    logic               end_reg;

    logic               emit;
    logic [3:0]         emit_kind;
    logic [31:0]        emit_value;
    logic [15:0]        emit_index;
    logic               emit_end;
    logic [31:0]        field_full;
    logic [31:0]        payload_count_inc;
    logic               last;
    logic [7:0]         b;

    assign b    = held.data;
    assign take = held.valid && (!out_valid_reg || out_ready);

    // The byte just received lands in its lane; the lanes above are still zero.
    assign field_full = field_acc_reg | ({24'd0, b} << {byte_in_field_reg, 3'b000});
    assign payload_count_inc = (payload_count_reg != 32'hFFFF_FFFF)
                               ? payload_count_reg + 32'd1 : payload_count_reg;
    assign last = ({1'b0, payload_count_inc} + HEADER_BYTES) >= {1'b0, packet_length_reg};

    always_comb
    begin
        phase_next         = phase_reg;
        byte_in_field_next = byte_in_field_reg;
        field_acc_next     = field_acc_reg;
        packet_length_next = packet_length_reg;
        payload_count_next = payload_count_reg;
        emit       = 1'b0;
        emit_kind  = KIND_NONE;
        emit_value = field_full;
        emit_index = 16'd0;
        emit_end   = 1'b0;

        if (phase_reg <= PHASE_MAGIC_LAST)
        begin
            phase_next = (b == magic_byte(phase_reg[2:0])) ? phase_reg + 5'd1 : PHASE_HUNT;
        end
        else if (phase_reg <= FIELD_LAST)
        begin
            if (byte_in_field_reg != BYTE_LAST)
            begin
                byte_in_field_next = byte_in_field_reg + 2'd1;
                field_acc_next     = field_full;
            end
            else
            begin
                byte_in_field_next = 2'd0;
                field_acc_next     = 32'd0;
                if (phase_reg == FIELD_LENGTH)
                begin
                    packet_length_next = field_full;
                end
                emit      = (phase_reg != FIELD_PLATFORM);
                emit_kind = field_kind(phase_reg);
                if (phase_reg == FIELD_LAST)
                begin
                    payload_count_next = 32'd0;
                    phase_next         = PHASE_PAYLOAD;
                end
                else
                begin
                    phase_next = phase_reg + 5'd1;
                end
            end
        end
        else if (phase_reg == PHASE_PAYLOAD)
        begin
            payload_count_next = payload_count_inc;
            emit       = 1'b1;
            emit_kind  = KIND_PAYLOAD;
            emit_value = {24'd0, b};
            emit_index = (payload_count_reg[31:16] != 16'd0) ? 16'hFFFF
                                                             : payload_count_reg[15:0];
            emit_end   = last;
            if (last)
            begin
                phase_next         = PHASE_HUNT;
                byte_in_field_next = 2'd0;
                field_acc_next     = 32'd0;
                packet_length_next = 32'd0;
                payload_count_next = 32'd0;
            end
        end
        else
        begin
            phase_next         = PHASE_HUNT;
            byte_in_field_next = 2'd0;
            field_acc_next     = 32'd0;
            packet_length_next = 32'd0;
            payload_count_next = 32'd0;
        end
    end

    assign out_valid_next = take ? emit : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PHASE_HUNT;
            byte_in_field_reg <= 2'd0;
            field_acc_reg     <= 32'd0;
            packet_length_reg <= 32'd0;
            payload_count_reg <= 32'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                phase_reg         <= phase_next;
                byte_in_field_reg <= byte_in_field_next;
                field_acc_reg     <= field_acc_next;
                packet_length_reg <= packet_length_next;
                payload_count_reg <= payload_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            kind_reg  <= emit_kind;
            value_reg <= emit_value;
            index_reg <= emit_index;
            end_reg   <= emit_end;
        end
    end

    assign out_valid     = out_valid_reg;
    assign item_kind     = kind_reg;
    assign item_value    = value_reg;
    assign payload_index = index_reg;
    assign frame_end     = end_reg;

    a_end_only_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && end_reg |-> kind_reg == KIND_PAYLOAD)
        else $error("frame end flagged on a header word");

    a_header_no_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg != KIND_PAYLOAD |-> index_reg == 16'd0)
        else $error("header word carries a payload index");

    a_end_rehunt: assert property (@(posedge clk) disable iff (!rst_n)
        take && phase_reg == PHASE_PAYLOAD && last |=> phase_reg == PHASE_HUNT
            && payload_count_reg == 32'd0 && packet_length_reg == 32'd0)
        else $error("parser did not return to hunting after frame end");

    a_magic_clean: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PHASE_MAGIC_LAST |-> byte_in_field_reg == 2'd0 && field_acc_reg == 32'd0)
        else $error("field assembly state left over while hunting");

endmodule

// File: design/radar_frame_header_parser.sv
// ----------------------------------------------------------------------------
// Radar frame header parser
// Finds the magic word on a byte stream, emits header fields and payload bytes.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Words
//  input     in_valid / in_ready  rx_byte, one received byte
//  output    out_valid/ out_ready item_kind, item_value, payload_index, frame_end
//
// One byte is accepted every cycle while the output side keeps up.
// A byte passes an input register, then the parser logic into the result register.
// A held result stalls the parser, which in turn holds the input register.
// Reset returns the parser to hunting for the first magic byte.
// ----------------------------------------------------------------------------
module radar_frame_header_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  item_kind,
    output logic [31:0] item_value,
    output logic [15:0] payload_index,
    output logic        frame_end
);
    import rfhp_pkg::*;

    rfhp_byte_t held;
    logic       take;

    rfhp_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .take     (take),
        .held     (held)
    );

    rfhp_parse u_parse (
        .clk           (clk),
        .rst_n         (rst_n),
        .held          (held),
        .take          (take),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .item_kind     (item_kind),
        .item_value    (item_value),
        .payload_index (payload_index),
        .frame_end     (frame_end)
    );

endmodule

// File: tb/radar_frame_header_parser_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Radar frame header parser testbench
// Drives byte streams through the parser with random gaps and output stalls.
// A directed script covers sync loss, field extremes and short frames. Random
// frames with noise and broken sync words follow, then one frame with the
// largest length that is left open. Every output word is checked against an
// in-bench model of the parser or the word a typed script row fixes.
// ----------------------------------------------------------------------------
module radar_frame_header_parser_tb;

    import rfhp_pkg::*;

    localparam int          RANDOM_BYTES   = 200;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam logic [63:0] SYNC_SEQ       = 64'h0708_0506_0304_0102;
    // Word kind for each header slot, slot 0 in the low nibble.
    localparam logic [39:0] SLOT_KINDS = {KIND_TLV_LEN, KIND_TLV_TYPE, KIND_SUBFRAME,
                                          KIND_TLV_CNT, KIND_OBJECTS, KIND_CYCLES,
                                          KIND_FRAME, KIND_NONE, KIND_LENGTH,
                                          KIND_VERSION};

    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_SILENT,
        CHK_TYPED
    } row_check_t;

    typedef struct packed {
        rfhp_kind_t  kind;
        logic [31:0] value;
        logic [15:0] index;
        logic        last;
    } parse_word_t;

    typedef struct packed {
        logic [63:0] bytes;
        logic [3:0]  nbytes;
        row_check_t  chk;
        parse_word_t want;
    } script_row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte   = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  item_kind;
    logic [31:0] item_value;
    logic [15:0] payload_index;
    logic        frame_end;

    bit          calm = 1'b0;
    int          stall_left = 0;
    int          quiet_cycles = 0;
    int          mismatch_count = 0;
    int          bytes_sent = 0;
    parse_word_t expected_words[$];

    // Parser model state, at its reset values.
    logic [4:0]  hdr_phase     = PHASE_HUNT;
    logic [1:0]  hdr_byte_pos  = 2'd0;
    logic [31:0] hdr_accum     = 32'd0;
    logic [31:0] frame_len     = 32'd0;
    logic [31:0] payload_taken = 32'd0;

    // Byte rows go out low byte first. A typed row fixes the word due on its
    // last byte; earlier bytes of that row are predicted.
    script_row_t script [0:29] = '{
        '{64'h0102, 4'd2, CHK_SILENT, '0},
        // This 02 breaks the sync and must not restart it.
        '{64'h02, 4'd1, CHK_SILENT, '0},
        '{64'h07_0805_0603_0401, 4'd7, CHK_SILENT, '0},
        '{SYNC_SEQ, 4'd8, CHK_SILENT, '0},
        '{64'hFFFF_FFFF, 4'd4, CHK_TYPED, '{KIND_VERSION, 32'hFFFF_FFFF, 16'd0, 1'b0}},
        '{64'd48, 4'd4, CHK_TYPED, '{KIND_LENGTH, 32'd48, 16'd0, 1'b0}},
        '{64'hA5A5_A5A5, 4'd4, CHK_SILENT, '0},
        '{64'h0, 4'd4, CHK_TYPED, '{KIND_FRAME, 32'd0, 16'd0, 1'b0}},
        '{64'h8000_0001, 4'd4, CHK_TYPED, '{KIND_CYCLES, 32'h8000_0001, 16'd0, 1'b0}},
        '{64'h1, 4'd4, CHK_TYPED, '{KIND_OBJECTS, 32'd1, 16'd0, 1'b0}},
        '{64'h7FFF_FFFF, 4'd4, CHK_TYPED, '{KIND_TLV_CNT, 32'h7FFF_FFFF, 16'd0, 1'b0}},
        '{64'h00FF_00FF, 4'd4, CHK_TYPED, '{KIND_SUBFRAME, 32'h00FF_00FF, 16'd0, 1'b0}},
        '{64'hFF00_FF00, 4'd4, CHK_TYPED, '{KIND_TLV_TYPE, 32'hFF00_FF00, 16'd0, 1'b0}},
        '{64'h1234_5678, 4'd4, CHK_TYPED, '{KIND_TLV_LEN, 32'h1234_5678, 16'd0, 1'b0}},
        // A length of 48 still takes one payload byte, and it ends the frame.
        '{64'hFF, 4'd1, CHK_TYPED, '{KIND_PAYLOAD, 32'h0000_00FF, 16'd0, 1'b1}},
        '{SYNC_SEQ, 4'd8, CHK_SILENT, '0},
        '{64'h0, 4'd4, CHK_TYPED, '{KIND_VERSION, 32'd0, 16'd0, 1'b0}},
        '{64'h0, 4'd4, CHK_TYPED, '{KIND_LENGTH, 32'd0, 16'd0, 1'b0}},
        '{64'h0000_0003_FFFF_FFFF, 4'd8, CHK_TYPED, '{KIND_FRAME, 32'd3, 16'd0, 1'b0}},
        '{64'hDEAD_BEEF_0BAD_F00D, 4'd8, CHK_PREDICT, '0},
        '{64'h0000_0002_5A5A_C3C3, 4'd8, CHK_PREDICT, '0},
        '{64'h0000_0100_0000_0006, 4'd8, CHK_PREDICT, '0},
        '{64'h00, 4'd1, CHK_TYPED, '{KIND_PAYLOAD, 32'd0, 16'd0, 1'b1}},
        '{SYNC_SEQ, 4'd8, CHK_SILENT, '0},
        '{64'h0000_0033_0000_0001, 4'd8, CHK_TYPED, '{KIND_LENGTH, 32'd51, 16'd0, 1'b0}},
        '{64'h1357_9BDF_2468_ACE0, 4'd8, CHK_PREDICT, '0},
        '{64'h0F0F_0F0F_F0F0_F0F0, 4'd8, CHK_PREDICT, '0},
        '{64'h3C3C_3C3C_9669_6996, 4'd8, CHK_PREDICT, '0},
        '{64'hCAFE_F00D_8421_1248, 4'd8, CHK_PREDICT, '0},
        '{64'h55_AA01, 4'd3, CHK_TYPED, '{KIND_PAYLOAD, 32'h55, 16'd2, 1'b1}}
    };

    radar_frame_header_parser u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .item_kind     (item_kind),
        .item_value    (item_value),
        .payload_index (payload_index),
        .frame_end     (frame_end)
    );

    always #5 clk = ~clk;

    // Steps the parser model by one byte; returns 1 when a word comes out.
    function automatic bit parse_byte(input logic [7:0] b, output parse_word_t w);
        logic [31:0] fld;
        logic [3:0]  slot;
        logic        last;
        w = '0;
        if (hdr_phase < FIELD_FIRST)
        begin
            if (b == SYNC_SEQ[8*hdr_phase +: 8])
                hdr_phase = hdr_phase + 5'd1;
            else
                hdr_phase = PHASE_HUNT;
            return 1'b0;
        end
        if (hdr_phase <= FIELD_LAST)
        begin
            hdr_accum = hdr_accum | ({24'd0, b} << (8 * hdr_byte_pos));
            if (hdr_byte_pos != BYTE_LAST)
            begin
                hdr_byte_pos = hdr_byte_pos + 2'd1;
                return 1'b0;
            end
            fld = hdr_accum;
            slot = 4'(hdr_phase - FIELD_FIRST);
            hdr_accum = 32'd0;
            hdr_byte_pos = 2'd0;
            if (hdr_phase == FIELD_LENGTH)
                frame_len = fld;
            w.kind = rfhp_kind_t'(SLOT_KINDS[4*slot +: 4]);
            w.value = fld;
            if (hdr_phase == FIELD_LAST)
            begin
                payload_taken = 32'd0;
                hdr_phase = PHASE_PAYLOAD;
                return 1'b1;
            end
            hdr_phase = hdr_phase + 5'd1;
            return (hdr_phase - 5'd1) != FIELD_PLATFORM;
        end
        if (hdr_phase == PHASE_PAYLOAD)
        begin
            w.kind = KIND_PAYLOAD;
            w.value = {24'd0, b};
            w.index = (payload_taken > 32'h0000_FFFF) ? 16'hFFFF : payload_taken[15:0];
            if (payload_taken != 32'hFFFF_FFFF)
                payload_taken = payload_taken + 32'd1;
            last = ({1'b0, payload_taken} + HEADER_BYTES) >= {1'b0, frame_len};
            w.last = last;
            if (!last)
                return 1'b1;
        end
        hdr_phase = PHASE_HUNT;
        hdr_byte_pos = 2'd0;
        hdr_accum = 32'd0;
        frame_len = 32'd0;
        payload_taken = 32'd0;
        return hdr_phase != hdr_phase || w.kind == KIND_PAYLOAD;
    endfunction

    // Offers one byte, waits for it to be taken and records what it should cause.
    task automatic send_byte(input logic [7:0] b, input row_check_t chk = CHK_PREDICT,
                             input parse_word_t want = '0);
        parse_word_t w;
        bit          got;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
        got = parse_byte(b, w);
        case (chk)
            CHK_PREDICT:
                if (got)
                    expected_words.push_back(w);
            CHK_TYPED:
                expected_words.push_back(want);
            default:
                ;
        endcase
    endtask

    task automatic send_frame(input logic [31:0] len, input int unsigned pay);
        logic [31:0] fld;
        for (int i = 0; i < 8; i++)
            send_byte(SYNC_SEQ[8*i +: 8]);
        for (int f = 0; f < 10; f++)
        begin
            case ($urandom_range(0, 5))
                0:       fld = 32'd0;
                1:       fld = 32'hFFFF_FFFF;
                default: fld = $urandom;
            endcase
            if (f == FIELD_LENGTH - FIELD_FIRST)
                fld = len;
            for (int k = 0; k < 4; k++)
                send_byte(fld[8*k +: 8]);
        end
        repeat (pay)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic drain_words();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else if (calm)
            out_ready <= 1'b1;
        else if (stall_left != 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            out_ready <= 1'b0;
            stall_left <= $urandom_range(0, 8);
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        parse_word_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected word: item_kind %0d item_value %h", item_kind, item_value);
                mismatch_count++;
            end
            else
            begin
                w = expected_words.pop_front();
                if (item_kind !== w.kind)
                begin
                    $error("item_kind: expected %0d, got %0d", w.kind, item_kind);
                    mismatch_count++;
                end
                if (item_value !== w.value)
                begin
                    $error("item_value: expected %h, got %h", w.value, item_value);
                    mismatch_count++;
                end
                if (payload_index !== w.index)
                begin
                    $error("payload_index: expected %0d, got %0d", w.index, payload_index);
                    mismatch_count++;
                end
                if (frame_end !== w.last)
                begin
                    $error("frame_end: expected %0d, got %0d", w.last, frame_end);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int          cut;
        int          frames;
        int          random_goal;
        logic [7:0]  junk;
        logic [31:0] len;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < 30; r++)
            for (int i = 0; i < script[r].nbytes; i++)
                if (i == script[r].nbytes - 1 || script[r].chk == CHK_SILENT)
                    send_byte(script[r].bytes[8*i +: 8], script[r].chk, script[r].want);
                else
                    send_byte(script[r].bytes[8*i +: 8]);

        // Random frames, each behind some line noise and now and then a
        // sync word that breaks off at a random byte.
        frames = 0;
        random_goal = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < random_goal)
        begin
            calm = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(0, 4))
                send_byte(8'($urandom));
            if ($urandom_range(0, 2) == 0)
            begin
                cut = $urandom_range(0, 7);
                for (int i = 0; i < cut; i++)
                    send_byte(SYNC_SEQ[8*i +: 8]);
                do
                    junk = 8'($urandom);
                while (junk == SYNC_SEQ[8*cut +: 8]);
                send_byte(junk);
            end
            if ($urandom_range(0, 4) == 0)
                len = $urandom_range(0, 48);
            else
                len = 48 + $urandom_range(1, 12);
            send_frame(len, (len > 48) ? len - 48 : 1);
            if (frames == 2)
                drain_words();
            frames++;
        end

        // A last frame with the largest length, left open.
        calm = 1'b1;
        send_frame(32'hFFFF_FFFF, 16);

        drain_words();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
